>>> rtl/baif_pkg.sv
// ----------------------------------------------------------------------------
// baif_pkg
// shared types and constants of the baro/imu altitude fusion core
// ----------------------------------------------------------------------------
package baif_pkg;

    // sequencer states: idle, output, and one per arithmetic step of an update
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_MUL,
        ST_ADD_DIV,
        ST_X_DIV,
        ST_X2_MUL,
        ST_W_MUL,
        ST_RAW_MUL,
        ST_RAW_DIV,
        ST_AB_DIV,
        ST_BV_MUL,
        ST_AV_DIV,
        ST_VI_MUL,
        ST_VI_DIV,
        ST_VF_MUL,
        ST_V_MUL,
        ST_AA_DIV,
        ST_PR_MUL,
        ST_PR_DIV,
        ST_AF_MUL,
        ST_A_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_GROUND_ALT,
        CFG_TAU_BARO_VEL,
        CFG_TAU_VEL,
        CFG_TAU_ALT,
        CFG_TRUST_TIME,
        CFG_DEP_LEVELS
    } cfg_idx_t;

    // result status codes
    localparam logic [1:0] STAT_INIT   = 2'd0;
    localparam logic [1:0] STAT_UPDATE = 2'd1;
    localparam logic [1:0] STAT_SKIP   = 2'd2;

    // configuration reset values
    localparam logic [23:0] RST_TAU_BARO_VEL = 24'd100000;
    localparam logic [23:0] RST_TAU_VEL      = 24'd500000;
    localparam logic [23:0] RST_TAU_ALT      = 24'd500000;
    localparam logic [23:0] RST_TRUST_TIME   = 24'd1000000;
    localparam logic [8:0]  RST_DEP_LEVELS   = 9'd2;

    localparam int US_PER_S  = 1000000;
    // divisor width: a 24 bit time constant plus dt
    localparam int DIV_DVS_W = 25;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/baif_serial_div.sv
// ----------------------------------------------------------------------------
// baif_serial_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module baif_serial_div
    import baif_pkg::*;
#(
    parameter int DVD_W = 52,
    parameter int DVS_W = 25
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/baro_imu_altitude_fusion_core.sv
// ----------------------------------------------------------------------------
// baro_imu_altitude_fusion_core
// complementary filter of barometric altitude and vertical acceleration
// ----------------------------------------------------------------------------
// The core takes one sensor sample per input beat and returns one result beat
// per sample: fused vertical velocity, fused altitude above ground, filtered
// baro velocity and a status code (initialized, updated, skipped). All values
// are signed fixed point with FRAC_BITS fraction bits. Samples are worked one
// at a time by a sequencer around one shared multiplier and one bit-serial
// divider that yields a single quotient bit per cycle. The first sample after
// reset and samples with a bad time step go from idle straight to the
// output state. An update runs 7 divisions (8 when the airbrake level
// changed, 6 when the baro is fully distrusted) plus the multiply steps
// between them, so its run time is set by the divider. A new sample is
// accepted as soon as the previous result sits in the output register,
// even if it is not yet taken. Configuration writes are taken at any time
// (cfg_ready is always high) and belong between samples.
// ----------------------------------------------------------------------------
module baro_imu_altitude_fusion_core
    import baif_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DT_US = 100000
)
(
    input  logic               clk,
    input  logic               rst_n,
    // sample channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        time_us,
    input  logic signed [31:0] baro_altitude,
    input  logic signed [31:0] accel_z,
    input  logic [7:0]         deployment_level,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] velocity_z,
    output logic signed [31:0] altitude_fused,
    output logic signed [31:0] baro_velocity,
    output logic [1:0]         status,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // dt width, multiplier operand widths, divider widths
    localparam int DT_W   = $clog2(MAX_DT_US + 1);
    localparam int MA_W   = 34;
    localparam int MB_W   = (FRAC_BITS + 3 > 21) ? FRAC_BITS + 3 : 21;
    localparam int PROD_W = MA_W + MB_W;
    localparam int DVD_W  = (FRAC_BITS + 24 > 52) ? FRAC_BITS + 24 : 52;
    localparam int DVS_W  = DIV_DVS_W;
    localparam int QW     = FRAC_BITS + 1;

    localparam logic [QW-1:0] Q_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW:0]   THREE_Q = {2'b11, {FRAC_BITS{1'b0}}};
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic out32(input logic signed [33:0] v);
        return (v[33:31] != 3'b000) && (v[33:31] != 3'b111);
    endfunction

    // sequencer
    state_t state_reg, state_next;
    logic   launched_reg, launched_next;
    logic   div_neg_reg, div_neg_next;

    // configuration
    logic signed [31:0] ground_reg, ground_next;
    logic [23:0] tau_bv_reg, tau_bv_next;
    logic [23:0] tau_v_reg, tau_v_next;
    logic [23:0] tau_a_reg, tau_a_next;
    logic [23:0] trust_time_reg, trust_time_next;
    logic [8:0]  levels_reg, levels_next;

    // filter state
    logic               init_reg, init_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic signed [31:0] last_baro_reg, last_baro_next;
    logic signed [31:0] bvf_reg, bvf_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] alt_reg, alt_next;
    logic [23:0]        tw_reg, tw_next;
    logic [7:0]         last_dep_reg, last_dep_next;

    // per-sample working registers
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic signed [31:0]  baro_reg, baro_next;
    logic signed [31:0]  accel_reg, accel_next;
    logic [7:0]          dep_diff_reg, dep_diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [QW-1:0]       x_reg, x_next;
    logic [QW-1:0]       w_reg, w_next;
    logic [QW-1:0]       a_reg, a_next;
    logic signed [31:0]  raw_reg, raw_next;
    logic signed [31:0]  vimu_reg, vimu_next;
    logic                vbad_reg, vbad_next;
    logic signed [31:0]  pred_reg, pred_next;
    logic                abad_reg, abad_next;
    logic [1:0]          status_reg, status_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] vel_out_reg, vel_out_next;
    logic signed [31:0] alt_out_reg, alt_out_next;
    logic signed [31:0] bv_out_reg, bv_out_next;
    logic [1:0]         stat_out_reg, stat_out_next;

    // shared arithmetic
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_sh;
    logic [PROD_W-1:0]        prod_mag;
    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic [DVD_W-1:0]         div_quo;
    div_stat_t                div_stat;

    // derived values
    logic signed [33:0] baro_diff;
    logic signed [31:0] baro_in;
    logic [31:0]        dt_full;
    logic [23:0]        trust;
    logic [8:0]         span;
    logic signed [33:0] quo_s34;

    assign mul_p    = mul_a * mul_b;
    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign prod_mag = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    // baro altitude above ground, saturated
    assign baro_diff = sx34(baro_altitude) - sx34(ground_reg);
    assign baro_in   = (baro_diff > sx34(S32_MAX)) ? S32_MAX :
                       (baro_diff < sx34(S32_MIN)) ? S32_MIN : baro_diff[31:0];

    assign dt_full = time_us - last_time_reg;
    assign trust   = (trust_time_reg == 24'd0) ? 24'd1 : trust_time_reg;
    assign span    = (levels_reg > 9'd2) ? levels_reg - 9'd1 : 9'd1;
    assign quo_s34 = div_neg_reg ? -$signed({1'b0, div_quo[32:0]})
                                 :  $signed({1'b0, div_quo[32:0]});

    baif_serial_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ADD_MUL:
            begin
                mul_a = {{(MA_W-24){1'b0}}, trust};
                mul_b = {{(MB_W-8){1'b0}}, dep_diff_reg};
            end
            ST_X2_MUL:
            begin
                mul_a = {{(MA_W-QW){1'b0}}, x_reg};
                mul_b = {{(MB_W-QW){1'b0}}, x_reg};
            end
            ST_W_MUL:
            begin
                // x^2 times (3 - 2x)
                mul_a = {{(MA_W-QW){1'b0}}, prod_sh[QW-1:0]};
                mul_b = {{(MB_W-QW-1){1'b0}}, THREE_Q - {x_reg, 1'b0}};
            end
            ST_RAW_MUL:
            begin
                mul_a = sx34(baro_reg) - sx34(last_baro_reg);
                mul_b = MB_W'(US_PER_S);
            end
            ST_BV_MUL:
            begin
                mul_a = sx34(bvf_reg) - sx34(raw_reg);
                mul_b = {{(MB_W-QW){1'b0}}, a_reg};
            end
            ST_VI_MUL:
            begin
                mul_a = sx34(accel_reg);
                mul_b = {{(MB_W-DT_W){1'b0}}, dt_reg};
            end
            ST_VF_MUL:
            begin
                mul_a = sx34(vimu_reg) - sx34(bvf_reg);
                mul_b = {{(MB_W-QW){1'b0}}, a_reg};
            end
            ST_V_MUL:
            begin
                mul_a = sx34(bvf_reg + prod_sh[31:0]) - sx34(vimu_reg);
                mul_b = {{(MB_W-QW){1'b0}}, w_reg};
            end
            ST_PR_MUL:
            begin
                mul_a = sx34(vel_reg);
                mul_b = {{(MB_W-DT_W){1'b0}}, dt_reg};
            end
            ST_AF_MUL:
            begin
                mul_a = sx34(pred_reg) - sx34(baro_reg);
                mul_b = {{(MB_W-QW){1'b0}}, a_reg};
            end
            ST_A_MUL:
            begin
                mul_a = sx34(baro_reg + prod_sh[31:0]) - sx34(pred_reg);
                mul_b = {{(MB_W-QW){1'b0}}, w_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands per step
    always_comb
    begin
        div_dvd = '0;
        div_dvs = '0;
        case (state_reg)
            ST_ADD_DIV:
            begin
                div_dvd = prod_mag[DVD_W-1:0];
                div_dvs = {{(DVS_W-9){1'b0}}, span};
            end
            ST_X_DIV:
            begin
                div_dvd = {{(DVD_W-24){1'b0}}, trust - tw_reg} << FRAC_BITS;
                div_dvs = {1'b0, trust};
            end
            ST_RAW_DIV:
            begin
                div_dvd = prod_mag[DVD_W-1:0];
                div_dvs = {{(DVS_W-DT_W){1'b0}}, dt_reg};
            end
            ST_AB_DIV:
            begin
                div_dvd = {{(DVD_W-24){1'b0}}, tau_bv_reg} << FRAC_BITS;
                div_dvs = {1'b0, tau_bv_reg} + {{(DVS_W-DT_W){1'b0}}, dt_reg};
            end
            ST_AV_DIV:
            begin
                div_dvd = {{(DVD_W-24){1'b0}}, tau_v_reg} << FRAC_BITS;
                div_dvs = {1'b0, tau_v_reg} + {{(DVS_W-DT_W){1'b0}}, dt_reg};
            end
            ST_AA_DIV:
            begin
                div_dvd = {{(DVD_W-24){1'b0}}, tau_a_reg} << FRAC_BITS;
                div_dvs = {1'b0, tau_a_reg} + {{(DVS_W-DT_W){1'b0}}, dt_reg};
            end
            ST_VI_DIV, ST_PR_DIV:
            begin
                div_dvd = prod_mag[DVD_W-1:0];
                div_dvs = DVS_W'(US_PER_S);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    // next state and datapath updates
    always_comb
    begin
        logic [32:0]        sum;
        logic signed [33:0] wide;
        logic [DVD_W-1:0]   neg_lim;
        logic [DVD_W-1:0]   pos_lim;

        sum     = '0;
        wide    = '0;
        neg_lim = {{(DVD_W-32){1'b0}}, 32'h8000_0000};
        pos_lim = {{(DVD_W-32){1'b0}}, 32'h7FFF_FFFF};

        state_next      = state_reg;
        launched_next   = launched_reg;
        div_neg_next    = div_neg_reg;
        div_start       = 1'b0;

        ground_next     = ground_reg;
        tau_bv_next     = tau_bv_reg;
        tau_v_next      = tau_v_reg;
        tau_a_next      = tau_a_reg;
        trust_time_next = trust_time_reg;
        levels_next     = levels_reg;

        init_next       = init_reg;
        last_time_next  = last_time_reg;
        last_baro_next  = last_baro_reg;
        bvf_next        = bvf_reg;
        vel_next        = vel_reg;
        alt_next        = alt_reg;
        tw_next         = tw_reg;
        last_dep_next   = last_dep_reg;

        dt_next         = dt_reg;
        baro_next       = baro_reg;
        accel_next      = accel_reg;
        dep_diff_next   = dep_diff_reg;
        prod_next       = prod_reg;
        x_next          = x_reg;
        w_next          = w_reg;
        a_next          = a_reg;
        raw_next        = raw_reg;
        vimu_next       = vimu_reg;
        vbad_next       = vbad_reg;
        pred_next       = pred_reg;
        abad_next       = abad_reg;
        status_next     = status_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        vel_out_next    = vel_out_reg;
        alt_out_next    = alt_out_reg;
        bv_out_next     = bv_out_reg;
        stat_out_next   = stat_out_reg;

        // register writes, taken whenever offered
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GROUND_ALT:   ground_next     = cfg_data;
                CFG_TAU_BARO_VEL: tau_bv_next     = cfg_data[23:0];
                CFG_TAU_VEL:      tau_v_next      = cfg_data[23:0];
                CFG_TAU_ALT:      tau_a_next      = cfg_data[23:0];
                CFG_TRUST_TIME:   trust_time_next = cfg_data[23:0];
                CFG_DEP_LEVELS:   levels_next     = cfg_data[8:0];
                default:          ground_next     = ground_reg;
            endcase
        end

        // every multiply step registers its product
        case (state_reg)
            ST_ADD_MUL, ST_X2_MUL, ST_W_MUL, ST_RAW_MUL, ST_BV_MUL, ST_VI_MUL,
            ST_VF_MUL, ST_V_MUL, ST_PR_MUL, ST_AF_MUL, ST_A_MUL:
                prod_next = mul_p;
            default:
                prod_next = prod_reg;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_OUT;
                    if (!init_reg)
                    begin
                        // first sample only loads the state
                        init_next      = 1'b1;
                        last_time_next = time_us;
                        last_baro_next = baro_in;
                        bvf_next       = '0;
                        vel_next       = '0;
                        alt_next       = baro_in;
                        tw_next        = '0;
                        last_dep_next  = deployment_level;
                        status_next    = STAT_INIT;
                    end
                    else
                    begin
                        last_time_next = time_us;
                        if (dt_full == 32'd0 || dt_full > 32'(MAX_DT_US))
                        begin
                            status_next = STAT_SKIP;
                        end
                        else
                        begin
                            dt_next       = dt_full[DT_W-1:0];
                            baro_next     = baro_in;
                            accel_next    = accel_z;
                            last_dep_next = deployment_level;
                            dep_diff_next = (deployment_level > last_dep_reg) ?
                                            deployment_level - last_dep_reg :
                                            last_dep_reg - deployment_level;
                            if (deployment_level == last_dep_reg)
                            begin
                                // countdown runs down by dt
                                tw_next = ({8'd0, tw_reg} > dt_full) ?
                                          tw_reg - dt_full[23:0] : 24'd0;
                                state_next = ST_X_DIV;
                            end
                            else
                            begin
                                state_next = ST_ADD_MUL;
                            end
                        end
                    end
                end
            end

            ST_ADD_MUL: state_next = ST_ADD_DIV;

            ST_ADD_DIV:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                    div_neg_next  = 1'b0;
                end
                else if (div_stat.done)
                begin
                    // extend the countdown, clamped to the trust time
                    launched_next = 1'b0;
                    sum     = {9'd0, tw_reg} + div_quo[32:0];
                    tw_next = (sum < {9'd0, trust}) ? sum[23:0] : trust;
                    state_next = ST_X_DIV;
                end
            end

            ST_X_DIV:
            begin
                if (!launched_reg)
                begin
                    if (tw_reg >= trust)
                    begin
                        // baro fully distrusted
                        x_next     = '0;
                        state_next = ST_X2_MUL;
                    end
                    else
                    begin
                        div_start     = 1'b1;
                        launched_next = 1'b1;
                        div_neg_next  = 1'b0;
                    end
                end
                else if (div_stat.done)
                begin
                    launched_next = 1'b0;
                    x_next        = div_quo[QW-1:0];
                    state_next    = ST_X2_MUL;
                end
            end

            ST_X2_MUL: state_next = ST_W_MUL;

            ST_W_MUL: state_next = ST_RAW_MUL;

            ST_RAW_MUL:
            begin
                // smoothstep weight, clamped at one
                w_next = (prod_sh[QW+1:0] > {2'b00, Q_ONE}) ? Q_ONE : prod_sh[QW-1:0];
                state_next = ST_RAW_DIV;
            end

            ST_RAW_DIV:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                    div_neg_next  = prod_reg[PROD_W-1];
                end
                else if (div_stat.done)
                begin
                    // raw baro velocity, saturated
                    launched_next  = 1'b0;
                    last_baro_next = baro_reg;
                    if (div_neg_reg)
                        raw_next = (div_quo > neg_lim) ? S32_MIN : -$signed(div_quo[31:0]);
                    else
                        raw_next = (div_quo > pos_lim) ? S32_MAX : $signed(div_quo[31:0]);
                    state_next = ST_AB_DIV;
                end
            end

            ST_AB_DIV, ST_AV_DIV, ST_AA_DIV:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                    div_neg_next  = 1'b0;
                    // fold in the blend from the multiply step before
                    if (state_reg == ST_AV_DIV)
                        bvf_next = raw_reg + prod_sh[31:0];
                    if (state_reg == ST_AA_DIV)
                        vel_next = vbad_reg ? 32'sd0 : vimu_reg + prod_sh[31:0];
                end
                else if (div_stat.done)
                begin
                    launched_next = 1'b0;
                    a_next        = div_quo[QW-1:0];
                    case (state_reg)
                        ST_AB_DIV: state_next = ST_BV_MUL;
                        ST_AV_DIV: state_next = ST_VI_MUL;
                        default:   state_next = ST_PR_MUL;
                    endcase
                end
            end

            ST_BV_MUL: state_next = ST_AV_DIV;

            ST_VI_MUL: state_next = ST_VI_DIV;

            ST_VI_DIV, ST_PR_DIV:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                    div_neg_next  = prod_reg[PROD_W-1];
                end
                else if (div_stat.done)
                begin
                    launched_next = 1'b0;
                    if (state_reg == ST_VI_DIV)
                    begin
                        // imu-integrated velocity
                        wide       = sx34(vel_reg) + quo_s34;
                        vimu_next  = wide[31:0];
                        vbad_next  = out32(wide);
                        state_next = ST_VF_MUL;
                    end
                    else
                    begin
                        // predicted altitude
                        wide       = sx34(alt_reg) + quo_s34;
                        pred_next  = wide[31:0];
                        abad_next  = out32(wide);
                        state_next = ST_AF_MUL;
                    end
                end
            end

            ST_VF_MUL: state_next = ST_V_MUL;

            ST_V_MUL: state_next = ST_AA_DIV;

            ST_PR_MUL: state_next = ST_PR_DIV;

            ST_AF_MUL: state_next = ST_A_MUL;

            ST_A_MUL: state_next = ST_FIN;

            ST_FIN:
            begin
                alt_next    = abad_reg ? baro_reg : pred_reg + prod_sh[31:0];
                status_next = STAT_UPDATE;
                state_next  = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vel_out_next   = vel_reg;
                    alt_out_next   = alt_reg;
                    bv_out_next    = bvf_reg;
                    stat_out_next  = status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launched_reg   <= 1'b0;
            ground_reg     <= '0;
            tau_bv_reg     <= RST_TAU_BARO_VEL;
            tau_v_reg      <= RST_TAU_VEL;
            tau_a_reg      <= RST_TAU_ALT;
            trust_time_reg <= RST_TRUST_TIME;
            levels_reg     <= RST_DEP_LEVELS;
            init_reg       <= 1'b0;
            last_time_reg  <= '0;
            last_baro_reg  <= '0;
            bvf_reg        <= '0;
            vel_reg        <= '0;
            alt_reg        <= '0;
            tw_reg         <= '0;
            last_dep_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            launched_reg   <= launched_next;
            ground_reg     <= ground_next;
            tau_bv_reg     <= tau_bv_next;
            tau_v_reg      <= tau_v_next;
            tau_a_reg      <= tau_a_next;
            trust_time_reg <= trust_time_next;
            levels_reg     <= levels_next;
            init_reg       <= init_next;
            last_time_reg  <= last_time_next;
            last_baro_reg  <= last_baro_next;
            bvf_reg        <= bvf_next;
            vel_reg        <= vel_next;
            alt_reg        <= alt_next;
            tw_reg         <= tw_next;
            last_dep_reg   <= last_dep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        div_neg_reg  <= div_neg_next;
        dt_reg       <= dt_next;
        baro_reg     <= baro_next;
        accel_reg    <= accel_next;
        dep_diff_reg <= dep_diff_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        w_reg        <= w_next;
        a_reg        <= a_next;
        raw_reg      <= raw_next;
        vimu_reg     <= vimu_next;
        vbad_reg     <= vbad_next;
        pred_reg     <= pred_next;
        abad_reg     <= abad_next;
        status_reg   <= status_next;
        vel_out_reg  <= vel_out_next;
        alt_out_reg  <= alt_out_next;
        bv_out_reg   <= bv_out_next;
        stat_out_reg <= stat_out_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign velocity_z     = vel_out_reg;
    assign altitude_fused = alt_out_reg;
    assign baro_velocity  = bv_out_reg;
    assign status         = stat_out_reg;

`ifndef SYNTH
    // divider only reports back to a step that launched it
    a_div_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> launched_reg)
        else $error("divider done without a launched step");

    // first accepted sample marks the filter initialized
    a_init_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !init_reg) |=> init_reg)
        else $error("first sample did not initialize");

    // baro weight never above one while blending
    a_w_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_V_MUL || state_reg == ST_A_MUL) |-> (w_reg <= Q_ONE))
        else $error("baro weight out of range");

    // a result with a free output register is posted at once
    a_out_post: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not posted");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the baro/imu altitude fusion core
// ----------------------------------------------------------------------------
// A short table of directed samples runs first: first sample after reset,
// zero and oversized time steps, timestamp wrap, the field extremes and
// airbrake level changes, including levels beyond the configured count. Then
// several phases of random sample streams run, each under its own register
// settings, the extreme settings among them. Every result beat is compared
// with a typed result or with a fixed point model of the filter kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    import baif_pkg::*;

    localparam int FRAC      = 16;
    localparam int DT_MAX    = 100000;
    localparam longint Q1    = 64'sd1 << FRAC;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    // no-progress cycles before the run is called hung
    localparam int STALL_LIMIT = 20000;
    // idle wait at the end of a drain, after the last result
    localparam int SETTLE_CYCLES = 600;
    localparam int N_PHASES      = 8;
    localparam int ITEMS_PER_PH  = 200;

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] alt;
        logic signed [31:0] bvel;
        logic [1:0]         stat;
    } fusion_result_t;

    typedef struct {
        logic [31:0]        t;
        logic signed [31:0] baro;
        logic signed [31:0] accel;
        logic [7:0]         dep;
        bit                 typed;
        fusion_result_t     res;
    } sample_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        time_us;
    logic signed [31:0] baro_altitude;
    logic signed [31:0] accel_z;
    logic [7:0]         deployment_level;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] velocity_z;
    logic signed [31:0] altitude_fused;
    logic signed [31:0] baro_velocity;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    baro_imu_altitude_fusion_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .time_us          (time_us),
        .baro_altitude    (baro_altitude),
        .accel_z          (accel_z),
        .deployment_level (deployment_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .velocity_z       (velocity_z),
        .altitude_fused   (altitude_fused),
        .baro_velocity    (baro_velocity),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock, 20 ns period
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // results still owed by the core, oldest first
    fusion_result_t pending_results[$];
    int  n_errors;
    int  n_samples;
    int  n_results;
    int  n_updates;
    int  n_skips;
    int  n_cfg;
    bit  no_idle;
    int  stall_cnt;

    // model copy of the registers
    longint      m_ground;
    int unsigned m_tau_bv;
    int unsigned m_tau_v;
    int unsigned m_tau_a;
    int unsigned m_trust;
    int unsigned m_levels;
    // model copy of the filter state
    bit          m_init;
    logic [31:0] m_last_t;
    longint      m_last_baro;
    longint      m_bvel;
    longint      m_vel;
    longint      m_alt;
    int unsigned m_wait;
    int unsigned m_last_dep;

    function automatic longint sat32(longint v);
        return v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
    endfunction

    function automatic bit out32(longint v);
        return v > S_MAX || v < S_MIN;
    endfunction

    // weight a on first, the rest on second, floor shift
    function automatic longint blend(longint a, longint first, longint second);
        return (a * first + (Q1 - a) * second) >>> FRAC;
    endfunction

    function automatic longint alpha(int unsigned tau, int unsigned dt);
        return (longint'(tau) <<< FRAC) / (longint'(tau) + longint'(dt));
    endfunction

    // advance the filter model by one sample and give its result beat
    function automatic fusion_result_t fuse_sample(logic [31:0] t, logic signed [31:0] b,
                                                   logic signed [31:0] acc, logic [7:0] d);
        fusion_result_t r;
        longint baro, accel, x, x2, w, raw, vimu, vf, v, pred, af, a;
        longint unsigned addv, sumv;
        int unsigned dt, trust, span, diff;
        bit vbad, abad;
        baro  = sat32(longint'(b) - m_ground);
        accel = longint'(acc);
        if (!m_init) begin
            m_last_t    = t;
            m_last_baro = baro;
            m_bvel      = 0;
            m_vel       = 0;
            m_alt       = baro;
            m_wait      = 0;
            m_last_dep  = d;
            m_init      = 1'b1;
            r.stat      = STAT_INIT;
        end
        else begin
            dt = t - m_last_t;
            m_last_t = t;
            if (dt == 0 || dt > DT_MAX) begin
                r.stat = STAT_SKIP;
            end
            else begin
                trust = m_trust != 0 ? m_trust : 1;
                span  = m_levels > 2 ? m_levels - 1 : 1;
                if (d == m_last_dep) begin
                    m_wait = m_wait > dt ? m_wait - dt : 0;
                end
                else begin
                    diff = d > m_last_dep ? d - m_last_dep : m_last_dep - d;
                    addv = longint'(trust) * diff / span;
                    sumv = longint'(m_wait) + addv;
                    m_wait = sumv < trust ? int'(sumv) : trust;
                end
                m_last_dep = d;
                // smoothstep baro weight from the distrust countdown
                if (m_wait >= trust)
                    x = 0;
                else
                    x = (longint'(trust - m_wait) <<< FRAC) / longint'(trust);
                x2 = (x * x) >>> FRAC;
                w  = (x2 * (3 * Q1 - 2 * x)) >>> FRAC;
                if (w > Q1) w = Q1;
                if (w < 0) w = 0;
                raw = sat32((baro - m_last_baro) * US_PER_S / longint'(dt));
                m_last_baro = baro;
                m_bvel = sat32(blend(alpha(m_tau_bv, dt), m_bvel, raw));
                a    = alpha(m_tau_v, dt);
                vimu = m_vel + accel * longint'(dt) / US_PER_S;
                vbad = out32(vimu);
                vf   = blend(a, vimu, m_bvel);
                v    = blend(w, vf, vimu);
                vbad = vbad || out32(v);
                m_vel = vbad ? 0 : v;
                a    = alpha(m_tau_a, dt);
                pred = m_alt + m_vel * longint'(dt) / US_PER_S;
                abad = out32(pred);
                af   = blend(a, pred, baro);
                v    = blend(w, af, pred);
                abad = abad || out32(v);
                m_alt = abad ? baro : v;
                r.stat = STAT_UPDATE;
            end
        end
        r.vel  = m_vel[31:0];
        r.alt  = m_alt[31:0];
        r.bvel = m_bvel[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        n_errors++;
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    endtask

    // one sample beat; valid only drops when the sender idles
    task automatic send_sample(logic [31:0] t, logic signed [31:0] b, logic signed [31:0] acc,
                               logic [7:0] d, bit typed, fusion_result_t typed_res);
        fusion_result_t r;
        while (!no_idle && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        time_us          <= t;
        baro_altitude    <= b;
        accel_z          <= acc;
        deployment_level <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = fuse_sample(t, b, acc, d);
        pending_results.push_back(typed ? typed_res : r);
        n_samples++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GROUND_ALT:   m_ground = longint'(signed'(data));
            CFG_TAU_BARO_VEL: m_tau_bv = data[23:0];
            CFG_TAU_VEL:      m_tau_v  = data[23:0];
            CFG_TAU_ALT:      m_tau_a  = data[23:0];
            CFG_TRUST_TIME:   m_trust  = data[23:0];
            CFG_DEP_LEVELS:   m_levels = data[8:0];
            default: ;
        endcase
        n_cfg++;
        @(posedge clk);
    endtask

    // let the core run dry before touching registers or ending
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random back-pressure and the check of each beat
    always @(posedge clk) begin
        fusion_result_t e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("[%0t] result beat with nothing expected", $realtime);
                end
                else begin
                    e = pending_results.pop_front();
                    if (status == STAT_UPDATE) n_updates++;
                    if (status == STAT_SKIP) n_skips++;
                    if (velocity_z !== e.vel)
                        report_mismatch("velocity_z", e.vel, velocity_z);
                    if (altitude_fused !== e.alt)
                        report_mismatch("altitude_fused", e.alt, altitude_fused);
                    if (baro_velocity !== e.bvel)
                        report_mismatch("baro_velocity", e.bvel, baro_velocity);
                    if (status !== e.stat)
                        report_mismatch("status", e.stat, status);
                end
            end
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // hang detection: cycles with no beat on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    // directed samples, typed results only where obvious
    sample_row_t rows[$];

    function automatic sample_row_t row(logic [31:0] t, logic signed [31:0] b,
                                        logic signed [31:0] acc, logic [7:0] d, bit typed,
                                        logic signed [31:0] v, logic signed [31:0] al,
                                        logic signed [31:0] bv, logic [1:0] st);
        sample_row_t s;
        s.t = t; s.baro = b; s.accel = acc; s.dep = d; s.typed = typed;
        s.res.vel = v; s.res.alt = al; s.res.bvel = bv; s.res.stat = st;
        return s;
    endfunction

    initial begin
        logic [31:0]        t_cur;
        logic signed [31:0] b_cur;
        logic signed [31:0] acc;
        logic [7:0]         d_cur;
        int unsigned        k, pick;
        n_errors = 0; n_samples = 0; n_results = 0; n_updates = 0; n_skips = 0;
        n_cfg = 0; no_idle = 0; stall_cnt = 0;
        m_ground = 0; m_tau_bv = RST_TAU_BARO_VEL; m_tau_v = RST_TAU_VEL;
        m_tau_a = RST_TAU_ALT; m_trust = RST_TRUST_TIME; m_levels = RST_DEP_LEVELS;
        m_init = 0; m_last_t = 0; m_last_baro = 0; m_bvel = 0; m_vel = 0; m_alt = 0;
        m_wait = 0; m_last_dep = 0;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        time_us          <= '0;
        baro_altitude    <= '0;
        accel_z          <= '0;
        deployment_level <= '0;
        out_ready        <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample only loads state; zero and oversized steps are skipped
        rows.push_back(row(32'd1000, 32'sh0064_0000, 0, 8'd0, 1,
                           0, 32'sh0064_0000, 0, STAT_INIT));
        rows.push_back(row(32'd1000, 32'sh0070_0000, 32'sh0100_0000, 8'd1, 1,
                           0, 32'sh0064_0000, 0, STAT_SKIP));
        rows.push_back(row(32'd101001, 32'sh0064_0000, 0, 8'd0, 1,
                           0, 32'sh0064_0000, 0, STAT_SKIP));
        // largest legal step, then the smallest
        rows.push_back(row(32'd201001, 32'sh0065_0000, 32'sh0009_CE80, 8'd0, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd201002, 32'sh0066_0000, 32'sh0009_CE80, 8'd0, 0, 0, 0, 0, 0));
        // field extremes with a full-range level swing
        rows.push_back(row(32'd202002, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd1, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd302002, 32'sh8000_0000, 32'sh8000_0000, 8'd0, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd302003, 32'sh7FFF_FFFF, 32'sh8000_0000, 8'd0, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd312003, 32'sh8000_0000, 32'sh7FFF_FFFF, 8'd1, 0, 0, 0, 0, 0));
        // level beyond the configured count, then back
        rows.push_back(row(32'd322003, 32'sh0000_0000, 0, 8'd255, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd332003, 32'sh0000_0000, 0, 8'd255, 0, 0, 0, 0, 0));
        rows.push_back(row(32'd342003, 32'sh0001_0000, 0, 8'd0, 0, 0, 0, 0, 0));
        // timestamp wrap: jump close to the top, then step across zero
        rows.push_back(row(32'hFFFF_FF00, 32'sh0001_0000, 0, 8'd0, 0, 0, 0, 0, 0));
        rows.push_back(row(32'h0000_0010, 32'sh0002_0000, 32'shFFF6_0000, 8'd0, 0, 0, 0, 0, 0));
        rows.push_back(row(32'h0000_2000, 32'sh0003_0000, 32'shFFF6_0000, 8'd0, 0, 0, 0, 0, 0));
        foreach (rows[i])
            send_sample(rows[i].t, rows[i].baro, rows[i].accel, rows[i].dep,
                        rows[i].typed, rows[i].res);
        drain();

        t_cur = 32'h0000_2000;
        b_cur = 32'sh0003_0000;
        d_cur = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            // phase 0 small extremes, phase 1 large extremes, rest random
            if (ph == 0) begin
                write_reg(CFG_GROUND_ALT, 32'h8000_0000);
                write_reg(CFG_TAU_BARO_VEL, 32'd1);
                write_reg(CFG_TAU_VEL, 32'd1);
                write_reg(CFG_TAU_ALT, 32'd1);
                write_reg(CFG_TRUST_TIME, 32'd1);
                write_reg(CFG_DEP_LEVELS, 32'd2);
            end
            else if (ph == 1) begin
                write_reg(CFG_GROUND_ALT, 32'h7FFF_FFFF);
                write_reg(CFG_TAU_BARO_VEL, 32'hFF_FFFF);
                write_reg(CFG_TAU_VEL, 32'hFF_FFFF);
                write_reg(CFG_TAU_ALT, 32'hFF_FFFF);
                write_reg(CFG_TRUST_TIME, 32'hFF_FFFF);
                write_reg(CFG_DEP_LEVELS, 32'd256);
            end
            else begin
                write_reg(CFG_GROUND_ALT, ($urandom_range(3) == 0) ? $urandom()
                                          : $urandom_range(32'h0200_0000) - 32'h0100_0000);
                write_reg(CFG_TAU_BARO_VEL, $urandom_range(1000, 300000));
                write_reg(CFG_TAU_VEL, $urandom_range(1, 2000000));
                write_reg(CFG_TAU_ALT, $urandom_range(1, 2000000));
                write_reg(CFG_TRUST_TIME, $urandom_range(1, 3000000));
                write_reg(CFG_DEP_LEVELS, $urandom_range(2, 256));
            end
            // one phase runs with neither side ever idling
            no_idle = (ph == 3);
            for (k = 0; k < ITEMS_PER_PH; k++) begin
                pick = $urandom_range(99);
                // time step: mostly legal, some zero, some too long or wrapped
                if (pick < 5)
                    t_cur = t_cur;
                else if (pick < 10)
                    t_cur = ($urandom_range(1) == 0) ? $urandom()
                                                    : t_cur + $urandom_range(100001, 2000000);
                else if (pick < 20)
                    t_cur = t_cur + $urandom_range(1, DT_MAX);
                else
                    t_cur = t_cur + $urandom_range(500, 20000);
                // baro: random walk, sometimes anything
                if ($urandom_range(99) < 6)
                    b_cur = $urandom();
                else
                    b_cur = b_cur + $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
                acc = ($urandom_range(99) < 6) ? $urandom()
                      : $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
                // airbrake level: mostly held, sometimes stepped, rarely anything
                pick = $urandom_range(99);
                if (pick < 3)
                    d_cur = $urandom_range(255);
                else if (pick < 15)
                    d_cur = $urandom_range(m_levels - 1);
                send_sample(t_cur, b_cur, acc, d_cur, 0, '0);
            end
            drain();
        end
        no_idle = 0;

        $display("covered %0d samples (%0d updates, %0d skipped steps), %0d register writes",
                 n_samples, n_updates, n_skips, n_cfg);
        $display("%0d result beats checked over %0d register settings", n_results, N_PHASES + 1);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> baro_imu_altitude_fusion_core.f
rtl/baif_pkg.sv
rtl/baif_serial_div.sv
rtl/baro_imu_altitude_fusion_core.sv
dv/tb.sv
